>>> hdl/imhq_pkg.sv
package imhq_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 16;
	localparam int VERTEX_BITS_DEF = 8;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_DEC   = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;
endpackage

>>> hdl/imhq_cmp.sv
// Shared pair comparator: a < b by key, then by vertex.
module imhq_cmp #(
	parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF,
	parameter int VERTEX_BITS = imhq_pkg::VERTEX_BITS_DEF
) (
	input  logic [KEY_BITS-1:0]    a_key,
	input  logic [VERTEX_BITS-1:0] a_vtx,
	input  logic [KEY_BITS-1:0]    b_key,
	input  logic [VERTEX_BITS-1:0] b_vtx,
	output logic                   less
);
	assign less = (a_key < b_key) || ((a_key == b_key) && (a_vtx < b_vtx));
endmodule

>>> hdl/indexed_min_heap_queue.sv
// Query and requests rejected at accept finish without touching the heap; push sifts
// the new item up level by level; decrease-key first scans slots for the vertex and
// then sifts up; pop moves the last item to the root and sifts it down level by level.
// One request at a time: busy is high from accept until the done strobe.
// Async active-low reset clears the count and control; heap slots are not cleared.
// Results show for one cycle on done; the receiver cannot stall.
module indexed_min_heap_queue #(
	parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF,
	parameter int VERTEX_BITS = imhq_pkg::VERTEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             req_type,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [VERTEX_BITS-1:0] vertex,
	output logic                   done,
	output logic [1:0]             status,
	output logic [KEY_BITS-1:0]    top_key,
	output logic [VERTEX_BITS-1:0] top_vertex,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                   is_empty
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY+1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2,
		S_UPRD = 4'd3, S_UPCMP = 4'd4, S_LASTRD = 4'd5, S_DNL = 4'd6,
		S_DNLC = 4'd7, S_DNR = 4'd8, S_DNRC = 4'd9, S_TOPRD = 4'd10,
		S_DONE = 4'd11, S_TOPW = 4'd12;

	logic [KEY_BITS-1:0]    mem_key [CAPACITY];
	logic [VERTEX_BITS-1:0] mem_vtx [CAPACITY];

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q, best_q, idx_q;
	logic [KEY_BITS-1:0] cur_key_q, best_key_q, rd_key_q;
	logic [VERTEX_BITS-1:0] cur_vtx_q, best_vtx_q, rd_vtx_q;
	logic [1:0] status_q;
	logic [VERTEX_BITS-1:0] find_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [KEY_BITS-1:0] wkey;
	logic [VERTEX_BITS-1:0] wvtx;

	logic [KEY_BITS-1:0] ca_key, cb_key;
	logic [VERTEX_BITS-1:0] ca_vtx, cb_vtx;
	logic lt;

	imhq_cmp #(.KEY_BITS(KEY_BITS), .VERTEX_BITS(VERTEX_BITS)) u_cmp (
		.a_key(ca_key), .a_vtx(ca_vtx), .b_key(cb_key), .b_vtx(cb_vtx), .less(lt)
	);

	logic [AW:0] lch, rch;
	logic [AW-1:0] parent;
	assign lch = {pos_q, 1'b1};
	assign rch = {pos_q, 1'b0} + (AW+1)'(2);
	assign parent = (pos_q - AW'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_key[waddr] <= wkey;
			mem_vtx[waddr] <= wvtx;
		end
		rd_key_q <= mem_key[raddr];
		rd_vtx_q <= mem_vtx[raddr];
	end

	// comparator operands
	always_comb begin
		ca_key = cur_key_q; ca_vtx = cur_vtx_q;
		cb_key = rd_key_q;  cb_vtx = rd_vtx_q;
		if (state_q == S_DNRC) begin
			ca_key = rd_key_q;   ca_vtx = rd_vtx_q;
			cb_key = best_key_q; cb_vtx = best_vtx_q;
		end else if (state_q == S_DNLC) begin
			ca_key = rd_key_q;  ca_vtx = rd_vtx_q;
			cb_key = cur_key_q; cb_vtx = cur_vtx_q;
		end
	end

	// memory port control
	always_comb begin
		we = 1'b0; waddr = pos_q; wkey = cur_key_q; wvtx = cur_vtx_q;
		raddr = '0;
		unique case (state_q)
			S_SCAN: raddr = idx_q;
			S_UPRD: raddr = parent;
			S_UPCMP: begin
				we = 1'b1;
				if (pos_q != '0 && lt) begin
					wkey = rd_key_q; wvtx = rd_vtx_q;
				end
			end
			S_LASTRD: raddr = count_q[AW-1:0];
			S_DNL: raddr = lch[AW-1:0];
			S_DNR: raddr = rch[AW-1:0];
			S_DNRC, S_DNLC: ;
			S_TOPW: begin
				we = 1'b1;
				if (best_q != pos_q) begin
					wkey = best_key_q; wvtx = best_vtx_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done <= 1'b0;
			status_q <= imhq_pkg::ST_OK;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					find_q <= vertex;
					cur_key_q <= key;
					cur_vtx_q <= vertex;
					idx_q <= '0;
					status_q <= imhq_pkg::ST_OK;
					unique case (req_type)
						imhq_pkg::REQ_PUSH: if (count_q >= CAP_C) begin
							status_q <= imhq_pkg::ST_FULL;
							state_q <= S_TOPRD;
						end else begin
							pos_q <= count_q[AW-1:0];
							count_q <= count_q + CW'(1);
							state_q <= S_UPRD;
						end
						imhq_pkg::REQ_POP: if (count_q == '0) begin
							status_q <= imhq_pkg::ST_EMPTY;
							state_q <= S_TOPRD;
						end else begin
							count_q <= count_q - CW'(1);
							pos_q <= '0;
							state_q <= S_LASTRD;
						end
						imhq_pkg::REQ_DEC: if (count_q == '0) begin
							status_q <= imhq_pkg::ST_NOTFOUND;
							state_q <= S_TOPRD;
						end else state_q <= S_SCAN;
						imhq_pkg::REQ_QUERY: state_q <= S_TOPRD;
					endcase
				end
				S_SCAN: state_q <= S_SCANW;
				S_SCANW: begin
					if (rd_vtx_q == find_q) begin
						pos_q <= idx_q;
						state_q <= S_UPRD;
					end else if ({1'b0, idx_q} + (AW+1)'(1) >= (AW+1)'(count_q)) begin
						status_q <= imhq_pkg::ST_NOTFOUND;
						state_q <= S_TOPRD;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_SCAN;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					// parent moves down into pos, or item lands at pos
					if (pos_q != '0 && lt) begin
						pos_q <= parent;
						state_q <= S_UPRD;
					end else state_q <= S_TOPRD;
				end
				S_LASTRD: state_q <= S_DNL;
				S_DNL: begin
					cur_key_q <= (pos_q == '0 && idx_q == '0) ? rd_key_q : cur_key_q;
					cur_vtx_q <= (pos_q == '0 && idx_q == '0) ? rd_vtx_q : cur_vtx_q;
					idx_q <= AW'(1);
					if (count_q == '0) state_q <= S_TOPRD;
					else if (lch >= (AW+1)'(count_q)) begin
						best_q <= pos_q;
						state_q <= S_TOPW;
					end else state_q <= S_DNLC;
				end
				S_DNLC: begin
					if (lt) begin
						best_q <= lch[AW-1:0];
						best_key_q <= rd_key_q; best_vtx_q <= rd_vtx_q;
					end else begin
						best_q <= pos_q;
						best_key_q <= cur_key_q; best_vtx_q <= cur_vtx_q;
					end
					if (rch >= (AW+1)'(count_q)) state_q <= S_TOPW;
					else state_q <= S_DNR;
				end
				S_DNR: state_q <= S_DNRC;
				S_DNRC: begin
					if (lt) begin
						best_q <= rch[AW-1:0];
						best_key_q <= rd_key_q; best_vtx_q <= rd_vtx_q;
					end
					state_q <= S_TOPW;
				end
				S_TOPW: begin
					// write winner at pos; item continues from the winner's slot
					if (best_q != pos_q) begin
						pos_q <= best_q;
						state_q <= S_DNL;
					end else state_q <= S_TOPRD;
				end
				S_TOPRD: state_q <= S_DONE;
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign status = status_q;
	assign entry_count = count_q;
	assign is_empty = (count_q == '0);
	assign top_key = (count_q == '0) ? '0 : rd_key_q;
	assign top_vertex = (count_q == '0) ? '0 : rd_vtx_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C) else $error("count overflow");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> $stable(count_q)) else $error("count moved idle");
`endif
endmodule

>>> sim/tb_indexed_min_heap_queue.sv
module tb_indexed_min_heap_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = imhq_pkg::CAPACITY_DEF;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] top_key;
		logic [7:0]  top_vertex;
		logic [6:0]  entry_count;
		logic        is_empty;
	} heap_word_t;

	class heap_scoreboard;
		logic [15:0] keys[CAP];
		logic [7:0]  verts[CAP];
		int          fill;
		heap_word_t  pending[$];
		int          errors;
		int          checked;

		function bit lower(int a, int b);
			if (keys[a] != keys[b])
				return keys[a] < keys[b];
			return verts[a] < verts[b];
		endfunction

		function void swap_slots(int a, int b);
			logic [15:0] k;
			logic [7:0]  v;
			k = keys[a];
			v = verts[a];
			keys[a] = keys[b];
			verts[a] = verts[b];
			keys[b] = k;
			verts[b] = v;
		endfunction

		function void bubble_up(int p);
			int par;
			while (p > 0) begin
				par = (p - 1) / 2;
				if (!lower(p, par))
					break;
				swap_slots(p, par);
				p = par;
			end
		endfunction

		function void note_request(logic [1:0] rq, logic [15:0] k, logic [7:0] v);
			heap_word_t w;
			int p, l, r, best, i;
			w.status = imhq_pkg::ST_OK;
			if (rq == imhq_pkg::REQ_PUSH) begin
				if (fill >= CAP)
					w.status = imhq_pkg::ST_FULL;
				else begin
					keys[fill] = k;
					verts[fill] = v;
					fill++;
					bubble_up(fill - 1);
				end
			end else if (rq == imhq_pkg::REQ_POP) begin
				if (fill == 0)
					w.status = imhq_pkg::ST_EMPTY;
				else begin
					fill--;
					keys[0] = keys[fill];
					verts[0] = verts[fill];
					p = 0;
					while (p < fill) begin
						l = 2 * p + 1;
						r = 2 * p + 2;
						best = p;
						if (l < fill && lower(l, best))
							best = l;
						if (r < fill && lower(r, best))
							best = r;
						if (best == p)
							break;
						swap_slots(p, best);
						p = best;
					end
				end
			end else if (rq == imhq_pkg::REQ_DEC) begin
				// first match from slot 0 upward
				for (i = 0; i < fill; i++)
					if (verts[i] == v)
						break;
				if (i >= fill)
					w.status = imhq_pkg::ST_NOTFOUND;
				else begin
					keys[i] = k;
					bubble_up(i);
				end
			end
			w.top_key = fill ? keys[0] : '0;
			w.top_vertex = fill ? verts[0] : '0;
			w.entry_count = 7'(fill);
			w.is_empty = (fill == 0);
			pending.insert(pending.size(), w);
		endfunction

		function void check_result(heap_word_t got);
			heap_word_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status);
				errors++;
			end
			if (got.top_key !== e.top_key) begin
				$error("top_key exp %0d got %0d", e.top_key, got.top_key);
				errors++;
			end
			if (got.top_vertex !== e.top_vertex) begin
				$error("top_vertex exp %0d got %0d", e.top_vertex, got.top_vertex);
				errors++;
			end
			if (got.entry_count !== e.entry_count) begin
				$error("entry_count exp %0d got %0d", e.entry_count, got.entry_count);
				errors++;
			end
			if (got.is_empty !== e.is_empty) begin
				$error("is_empty exp %0d got %0d", e.is_empty, got.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, start, busy, done, is_empty;
	logic [1:0]  req_type, status;
	logic [15:0] key, top_key;
	logic [7:0]  vertex, top_vertex;
	logic [6:0]  entry_count;
	int          cycles = 0;
	int          sent;
	int          seen_full, seen_empty, seen_missing;
	heap_scoreboard board;

	indexed_min_heap_queue uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key(key), .vertex(vertex), .done(done),
		.status(status), .top_key(top_key), .top_vertex(top_vertex),
		.entry_count(entry_count), .is_empty(is_empty)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result('{status, top_key, top_vertex, entry_count, is_empty});
			if (status == imhq_pkg::ST_FULL) seen_full++;
			if (status == imhq_pkg::ST_EMPTY) seen_empty++;
			if (status == imhq_pkg::ST_NOTFOUND) seen_missing++;
		end
	end

	// start stays high across a zero gap; the next word is driven at the accept edge
	task automatic send_request(logic [1:0] rq, logic [15:0] k, logic [7:0] v);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		key <= k;
		vertex <= v;
		// accepted at the first edge where busy is low
		do @(posedge clk); while (busy);
		board.note_request(rq, k, v);
		sent++;
	endtask

	// vertex of some live entry (random when empty), small pool to get duplicates
	function automatic logic [7:0] live_vertex();
		if (board.fill == 0)
			return 8'($urandom_range(0, 255));
		return board.verts[$urandom_range(0, board.fill - 1)];
	endfunction

	initial begin
		int n, mode, roll;
		logic [1:0] rq;
		board = new();
		sent = 0;
		arst_n = 0;
		start = 0;
		req_type = imhq_pkg::REQ_QUERY;
		key = '0;
		vertex = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, extremes, ties, duplicates, full
		send_request(imhq_pkg::REQ_POP, 16'h0, 8'h0);
		send_request(imhq_pkg::REQ_QUERY, 16'hFFFF, 8'hFF);
		send_request(imhq_pkg::REQ_DEC, 16'h0, 8'h5);
		send_request(imhq_pkg::REQ_PUSH, 16'hFFFF, 8'hFF);
		send_request(imhq_pkg::REQ_PUSH, 16'h0000, 8'h00);
		send_request(imhq_pkg::REQ_PUSH, 16'h0000, 8'h00);
		send_request(imhq_pkg::REQ_PUSH, 16'h1234, 8'hA5);
		send_request(imhq_pkg::REQ_PUSH, 16'h1234, 8'h5A);
		send_request(imhq_pkg::REQ_DEC, 16'h0001, 8'hFF);
		send_request(imhq_pkg::REQ_DEC, 16'hFFFF, 8'h00);
		send_request(imhq_pkg::REQ_DEC, 16'h0, 8'h77);
		send_request(imhq_pkg::REQ_QUERY, 16'h0, 8'h0);
		for (int i = 0; i < CAP; i++)
			send_request(imhq_pkg::REQ_PUSH, 16'($urandom_range(0, 65535)),
				8'($urandom_range(0, 255)));
		send_request(imhq_pkg::REQ_PUSH, 16'hAAAA, 8'h55);
		send_request(imhq_pkg::REQ_DEC, 16'h0, live_vertex());
		while (board.fill > 0)
			send_request(imhq_pkg::REQ_POP, 16'($urandom), 8'($urandom));
		send_request(imhq_pkg::REQ_POP, 16'h5555, 8'hAA);

		// random: phases that favor growth, drain or churn
		for (n = 0; n < 360; n++) begin
			if (n % 60 == 0)
				mode = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (mode == 0)
				rq = roll < 60 ? imhq_pkg::REQ_PUSH : roll < 75 ? imhq_pkg::REQ_DEC :
					roll < 92 ? imhq_pkg::REQ_POP : imhq_pkg::REQ_QUERY;
			else if (mode == 1)
				rq = roll < 25 ? imhq_pkg::REQ_PUSH : roll < 40 ? imhq_pkg::REQ_DEC :
					roll < 92 ? imhq_pkg::REQ_POP : imhq_pkg::REQ_QUERY;
			else
				rq = roll < 40 ? imhq_pkg::REQ_PUSH : roll < 70 ? imhq_pkg::REQ_DEC :
					roll < 92 ? imhq_pkg::REQ_POP : imhq_pkg::REQ_QUERY;
			if ($urandom_range(0, 1))
				send_request(rq, 16'($urandom_range(0, 65535)),
					($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : live_vertex());
			else
				send_request(rq, 16'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
		end
		start <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d requests, %0d results checked", sent, board.checked);
		$display("Status hits: full %0d, empty %0d, missing vertex %0d",
			seen_full, seen_empty, seen_missing);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
